// ===== hdl/sac_pkg.sv =====
// Package for the set-associative LFU cache: geometry constants, command codes,
// register indexes, state encoding and the tag-store row type. No dependencies.
package sac_pkg;

    localparam int MAX_SET_BITS   = 4;
    localparam int MAX_BLOCK_BITS = 4;
    localparam int MAX_WAYS       = 4;
    localparam int ADDR_BITS      = 12;

    localparam int CFG_W   = 3;
    localparam int CIDX_W  = 2;
    localparam int DATA_W  = 8;
    localparam int CNT_W   = 8;
    localparam int SET_W   = MAX_SET_BITS;
    localparam int OFF_W   = (MAX_BLOCK_BITS > 0) ? MAX_BLOCK_BITS : 1;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SETS    = 1 << MAX_SET_BITS;
    localparam int LINE_W  = SET_W + WAY_W;
    localparam int LINES   = 1 << LINE_W;
    localparam int LB_AW   = LINE_W + OFF_W;
    localparam int SB_W    = $clog2(MAX_SET_BITS + MAX_BLOCK_BITS + 1);
    localparam int MEM_SIZE = 1 << ADDR_BITS;

    localparam logic [CIDX_W-1:0] REG_SET_BITS   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_BLOCK_BITS = 2'd1;
    localparam logic [CIDX_W-1:0] REG_WAYS_USED  = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_WB_RD,
        S_WB_WR,
        S_FILL_RD,
        S_FILL_WR,
        S_ACCESS,
        S_RDOUT
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0]     count;
        logic [ADDR_BITS-1:0] tag;
    } t_meta;

    typedef t_meta [MAX_WAYS-1:0] t_row;

endpackage

// ===== hdl/sac_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Uses no package.
module sac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/set_assoc_cache_lfu.sv =====
// Set-associative write-through cache with LFU replacement and backing memory.
// Depends on sac_pkg and sac_ram (tag store, line data, backing memory).
//
// Usage:
//   Command channel: drive i_cmd, i_address, i_write_data with start high; the
//   item is taken at a clock edge where start is high and busy is low. busy
//   stays high until the result has been issued.
//   Result channel: o_valid is high for one cycle with o_read_data and o_hit.
//   The receiver cannot stall; a result is never held.
//   Config channel: i_cfg_valid with i_cfg_index and i_cfg_data; o_cfg_ready
//   is always high. Write only while busy is low.
// Sequence: S_LOOK first; a load, an unused command or a write hit ends
//   there, a read hit goes on to S_RDOUT. A miss writes back the victim block
//   when the victim is valid, then refills the block from backing memory, then
//   goes to S_ACCESS (and S_RDOUT for a read). Each block byte is moved by a
//   read state and a write state through RAMs with one read and one write port each.
// Next item may start in the cycle the result appears.
// Reset (synchronous): all lines invalid, and an invalid way is seen as use count 0
// and tag 0; config at set_bits 2, block_bits 2, ways_used 2. No clearing pass is needed.
module set_assoc_cache_lfu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_cmd,
    input  logic [sac_pkg::ADDR_BITS-1:0] i_address,
    input  logic [sac_pkg::DATA_W-1:0]    i_write_data,
    output logic                          o_valid,
    output logic [sac_pkg::DATA_W-1:0]    o_read_data,
    output logic                          o_hit,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sac_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [sac_pkg::CFG_W-1:0]     i_cfg_data
);
    import sac_pkg::*;

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [ADDR_BITS-1:0] r_addr, r_tag, r_base, r_old;
    logic [DATA_W-1:0]    r_data;
    logic [SET_W-1:0]     r_set;
    logic [WAY_W-1:0]     r_way;
    logic [OFF_W-1:0]     r_cnt;
    logic                 r_hit, r_wb;
    logic [LINES-1:0]     r_valid;
    logic [CFG_W-1:0]     r_set_bits, r_block_bits, r_ways_used;
    logic                 r_out_valid, r_out_hit;
    logic [DATA_W-1:0]    r_out_data;

    logic [CFG_W-1:0]     eff_s, eff_b, eff_e;
    logic [SB_W-1:0]      sb;
    logic [SET_W-1:0]     smask, in_set;
    logic [OFF_W-1:0]     bmask, off;
    logic                 accept, last;

    t_row                 meta_rdata, meta_wrow;
    logic                 meta_we;
    logic [SET_W-1:0]     meta_raddr;
    logic [MAX_WAYS-1:0]  way_valid, way_hit;
    logic [CNT_W-1:0]     way_cnt [MAX_WAYS];
    logic [ADDR_BITS-1:0] way_tag [MAX_WAYS];
    logic                 any_hit;
    logic [WAY_W-1:0]     hit_way, victim;

    logic                 lb_we;
    logic [LB_AW-1:0]     lb_waddr, lb_raddr;
    logic [DATA_W-1:0]    lb_wdata, lb_rdata;
    logic                 bk_we;
    logic [ADDR_BITS-1:0] bk_waddr, bk_raddr;
    logic [DATA_W-1:0]    bk_wdata, bk_rdata;
    logic                 n_out_valid, n_out_hit;
    logic [DATA_W-1:0]    n_out_data;

    assign eff_s = (r_set_bits > CFG_W'(MAX_SET_BITS)) ? CFG_W'(MAX_SET_BITS) : r_set_bits;
    assign eff_b = (r_block_bits > CFG_W'(MAX_BLOCK_BITS)) ?
                   CFG_W'(MAX_BLOCK_BITS) : r_block_bits;
    assign eff_e = (r_ways_used == '0) ? CFG_W'(1) :
                   (r_ways_used > CFG_W'(MAX_WAYS)) ? CFG_W'(MAX_WAYS) : r_ways_used;
    assign sb     = SB_W'(eff_s) + SB_W'(eff_b);
    assign smask  = ~({SET_W{1'b1}} << eff_s);
    assign bmask  = ~({OFF_W{1'b1}} << eff_b);
    assign in_set = SET_W'(i_address >> eff_b) & smask;
    assign off    = OFF_W'(r_addr) & bmask;
    assign last   = (r_cnt == bmask);
    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign meta_raddr  = in_set;

    always_comb begin
        way_valid = '0;
        way_hit   = '0;
        any_hit   = 1'b0;
        hit_way   = '0;
        victim    = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            way_valid[w] = (CFG_W'(w) < eff_e) && r_valid[{r_set, WAY_W'(w)}];
            way_cnt[w]   = way_valid[w] ? meta_rdata[w].count : '0;
            way_tag[w]   = way_valid[w] ? meta_rdata[w].tag : '0;
            way_hit[w]   = way_valid[w] && (way_tag[w] == r_tag);
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (way_hit[w]) begin
                any_hit = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
        for (int w = 1; w < MAX_WAYS; w++) begin
            if ((CFG_W'(w) < eff_e) && (way_cnt[w] < way_cnt[victim])) begin
                victim = WAY_W'(w);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (start) n_state = S_LOOK;
            S_LOOK: begin
                if (r_cmd != CMD_READ && r_cmd != CMD_WRITE) begin
                    n_state = S_IDLE;
                end else if (any_hit) begin
                    n_state = (r_cmd == CMD_READ) ? S_RDOUT : S_IDLE;
                end else begin
                    n_state = way_valid[victim] ? S_WB_RD : S_FILL_RD;
                end
            end
            S_WB_RD:   n_state = S_WB_WR;
            S_WB_WR:   n_state = last ? S_FILL_RD : S_WB_RD;
            S_FILL_RD: n_state = S_FILL_WR;
            S_FILL_WR: n_state = last ? S_ACCESS : S_FILL_RD;
            S_ACCESS:  n_state = (r_cmd == CMD_READ) ? S_RDOUT : S_IDLE;
            S_RDOUT:   n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        meta_we     = 1'b0;
        meta_wrow   = meta_rdata;
        lb_we       = 1'b0;
        lb_waddr    = {r_set, r_way, off};
        lb_wdata    = r_data;
        lb_raddr    = {r_set, r_way, off};
        bk_we       = 1'b0;
        bk_waddr    = r_addr;
        bk_wdata    = r_data;
        bk_raddr    = r_base | ADDR_BITS'(r_cnt);
        n_out_valid = 1'b0;
        n_out_hit   = 1'b0;
        n_out_data  = '0;
        case (r_state)
            S_LOOK: begin
                if (r_cmd == CMD_LOAD) begin
                    bk_we       = 1'b1;
                    n_out_valid = 1'b1;
                end else if (r_cmd == CMD_NONE) begin
                    n_out_valid = 1'b1;
                end else if (any_hit) begin
                    meta_we = 1'b1;
                    if (meta_rdata[hit_way].count != {CNT_W{1'b1}}) begin
                        meta_wrow[hit_way].count = meta_rdata[hit_way].count + 1'b1;
                    end
                    lb_raddr = {r_set, hit_way, off};
                    lb_waddr = {r_set, hit_way, off};
                    if (r_cmd == CMD_WRITE) begin
                        lb_we       = 1'b1;
                        bk_we       = 1'b1;
                        n_out_valid = 1'b1;
                        n_out_hit   = 1'b1;
                    end
                end else begin
                    meta_we                 = 1'b1;
                    meta_wrow[victim].count = CNT_W'(1);
                    meta_wrow[victim].tag   = r_tag;
                end
            end
            S_WB_RD: lb_raddr = {r_set, r_way, r_cnt};
            S_WB_WR: begin
                bk_we    = 1'b1;
                bk_waddr = r_old | ADDR_BITS'(r_cnt);
                bk_wdata = lb_rdata;
            end
            S_FILL_WR: begin
                lb_we    = 1'b1;
                lb_waddr = {r_set, r_way, r_cnt};
                lb_wdata = bk_rdata;
            end
            S_ACCESS: begin
                if (r_cmd == CMD_WRITE) begin
                    lb_we       = 1'b1;
                    bk_we       = 1'b1;
                    n_out_valid = 1'b1;
                end
            end
            S_RDOUT: begin
                n_out_valid = 1'b1;
                n_out_hit   = r_hit;
                n_out_data  = lb_rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_set_bits   <= CFG_W'(2);
            r_block_bits <= CFG_W'(2);
            r_ways_used  <= CFG_W'(2);
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_SET_BITS:   r_set_bits   <= i_cfg_data;
                    REG_BLOCK_BITS: r_block_bits <= i_cfg_data;
                    REG_WAYS_USED:  r_ways_used  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_LOOK) begin
                r_cnt <= '0;
                if ((r_cmd == CMD_READ || r_cmd == CMD_WRITE) && !any_hit) begin
                    r_valid[{r_set, victim}] <= 1'b1;
                end
            end else if (r_state == S_WB_WR || r_state == S_FILL_WR) begin
                r_cnt <= last ? '0 : r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_hit  <= n_out_hit;
        r_out_data <= n_out_data;
        if (accept) begin
            r_cmd  <= t_cmd'(i_cmd);
            r_addr <= i_address;
            r_data <= i_write_data;
            r_set  <= in_set;
            r_tag  <= i_address >> sb;
            r_base <= i_address & ~ADDR_BITS'(bmask);
        end
        if (r_state == S_LOOK) begin
            r_hit <= any_hit;
            r_way <= any_hit ? hit_way : victim;
            r_wb  <= way_valid[victim];
            r_old <= (way_tag[victim] << sb) | (ADDR_BITS'(r_set) << eff_b);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_hit       = r_out_hit;
    assign o_read_data = r_out_data;

    sac_ram #(.WIDTH($bits(t_row)), .DEPTH(SETS)) u_meta (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (r_set),
        .i_wdata (meta_wrow),
        .i_raddr (meta_raddr),
        .o_rdata (meta_rdata)
    );

    sac_ram #(.WIDTH(DATA_W), .DEPTH(1 << LB_AW)) u_lines (
        .i_clk   (i_clk),
        .i_we    (lb_we),
        .i_waddr (lb_waddr),
        .i_wdata (lb_wdata),
        .i_raddr (lb_raddr),
        .o_rdata (lb_rdata)
    );

    sac_ram #(.WIDTH(DATA_W), .DEPTH(MEM_SIZE)) u_backing (
        .i_clk   (i_clk),
        .i_we    (bk_we),
        .i_waddr (bk_waddr),
        .i_wdata (bk_wdata),
        .i_raddr (bk_raddr),
        .o_rdata (bk_rdata)
    );

`ifndef SYNTHESIS
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result issued while busy");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted item did not start");
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !busy)) else $error("activity after reset");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL_WR || r_state == S_WB_WR) |-> ((r_cnt & ~bmask) == '0))
        else $error("block byte counter out of range");
    a_wb_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB_RD) |-> r_wb) else $error("write-back of invalid victim");
`endif
endmodule
